// ===== hw/rtl/radio_api_transmit_framer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Transmit framer assertion macros
// Shared concurrent check forms used by the framer RTL.
// ----------------------------------------------------------------------------
`ifndef RADIO_API_TRANSMIT_FRAMER_CORE_ASSERT_SVH
`define RADIO_API_TRANSMIT_FRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define RTF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer check failed: same-cycle implication");

// next-cycle implication
`define RTF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer check failed: next-cycle implication");

`endif

// ===== hw/rtl/rtf_pkg.sv =====
// ----------------------------------------------------------------------------
// Transmit framer package
// Types, constants and helpers shared by the framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtf_pkg;

   localparam int HDR_LEN     = 17;
   localparam int MAX_RESULTS = HDR_LEN + 1;
   localparam int LEN_BIAS    = 14;
   localparam int MAX_PAYLOAD = 256;
   localparam int ADDR_BYTES  = 8;
   localparam int LEN_W       = 9;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int REG_IDX_W   = 3;
   localparam int PADDR_W     = 5;
   localparam int PDATA_W     = 32;

   // header byte offsets
   localparam int OFF_DELIM   = 0;
   localparam int OFF_LEN_HI  = 1;
   localparam int OFF_LEN_LO  = 2;
   localparam int OFF_KIND    = 3;
   localparam int OFF_IDENT   = 4;
   localparam int OFF_ADDR    = 5;
   localparam int OFF_RSV_HI  = 13;
   localparam int OFF_RSV_LO  = 14;
   localparam int OFF_RADIUS  = 15;
   localparam int OFF_OPTIONS = 16;
   localparam int OFF_CKSUM   = 17;

   localparam logic [7:0] CKSUM_BASE = 8'hFF;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_START_DELIM = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_KIND  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_IDENT = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RSV_HIGH    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_RSV_LOW     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_RADIUS      = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_OPTIONS     = 3'd6;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic             command;
      logic [63:0]      dest_address;
      logic [LEN_W-1:0] payload_length;
      byte_type         payload_byte;
   } req_type;

   typedef struct packed {
      byte_type out_byte;
      logic     frame_end;
      logic     run_end;
      logic     error;
   } rsp_type;

   typedef struct packed {
      byte_type start_delimiter;
      byte_type frame_kind;
      byte_type frame_ident;
      byte_type reserved_high;
      byte_type reserved_low;
      byte_type broadcast_radius;
      byte_type send_options;
      byte_type cfg_sum;        // mod-256 sum of the checksummed register bytes
   } cfg_type;

   function automatic byte_type addr_sum(input logic [63:0] addr);
      byte_type s;
      s = '0;
      for (int i = 0; i < ADDR_BYTES; i++) begin
         s = s + addr[8*i +: 8];
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/radio_api_transmit_framer_core.sv =====
// ----------------------------------------------------------------------------
// Radio API transmit-request framer
// Turns start and data words into a serialized transmit-request frame.
// ----------------------------------------------------------------------------
// A start word loads the whole 17-byte header (plus the checksum for an empty
// frame) into a byte shift register, which then drains one byte per cycle into
// the result register while the result side keeps up.
// A data word yields one byte, or two when it closes the frame, and data words
// are taken one per cycle while the result side keeps up: the next word is
// accepted in the cycle the previous word's last byte moves to the output.
// Header register bytes are sampled when the start word is accepted.
`default_nettype none

`include "radio_api_transmit_framer_core_assert.svh"

module radio_api_transmit_framer_core
   import rtf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   cfg_type cfg;

   rtf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // pending bytes of the current word, front at index 0
   byte_type         job_bytes_ff [MAX_RESULTS];
   byte_type         job_bytes_in [MAX_RESULTS];
   logic [CNT_W-1:0] job_left_ff, job_left_in;
   logic             job_ck_ff, job_ck_in;
   logic             job_err_ff, job_err_in;

   byte_type         running_sum_ff, running_sum_in;
   logic [LEN_W-1:0] bytes_rem_ff, bytes_rem_in;
   logic             frame_open_ff, frame_open_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             out_load;
   logic             last_byte;
   logic             accept;
   logic [LEN_W-1:0] len_sat;
   logic [LEN_W-1:0] tlen;
   byte_type         hdr_sum;
   byte_type         data_sum;
   logic [LEN_W-1:0] rem_dec;

   assign last_byte = (job_left_ff == CNT_W'(1));
   assign out_load  = (job_left_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (job_left_ff == '0) || (last_byte && out_load);
   assign accept    = req_valid && req_ready;

   assign len_sat  = (req_data.payload_length > LEN_W'(MAX_PAYLOAD)) ?
                     LEN_W'(MAX_PAYLOAD) : req_data.payload_length;
   assign tlen     = len_sat + LEN_W'(LEN_BIAS);
   assign hdr_sum  = cfg.cfg_sum + addr_sum(req_data.dest_address);
   assign data_sum = running_sum_ff + req_data.payload_byte;
   assign rem_dec  = bytes_rem_ff - LEN_W'(1);

   always_comb begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
         job_bytes_in[i] = out_load ? job_bytes_ff[i+1] : job_bytes_ff[i];
      end
      job_bytes_in[MAX_RESULTS-1] = job_bytes_ff[MAX_RESULTS-1];
      job_left_in    = job_left_ff - CNT_W'(out_load);
      job_ck_in      = job_ck_ff;
      job_err_in     = job_err_ff;
      running_sum_in = running_sum_ff;
      bytes_rem_in   = bytes_rem_ff;
      frame_open_in  = frame_open_ff;

      if (accept) begin
         case (req_data.command)
            CMD_START: begin
               job_bytes_in[OFF_DELIM]   = cfg.start_delimiter;
               job_bytes_in[OFF_LEN_HI]  = byte_type'(tlen >> 8);
               job_bytes_in[OFF_LEN_LO]  = tlen[7:0];
               job_bytes_in[OFF_KIND]    = cfg.frame_kind;
               job_bytes_in[OFF_IDENT]   = cfg.frame_ident;
               for (int i = 0; i < ADDR_BYTES; i++) begin
                  job_bytes_in[OFF_ADDR+i] =
                     req_data.dest_address[8*(ADDR_BYTES-1-i) +: 8];
               end
               job_bytes_in[OFF_RSV_HI]  = cfg.reserved_high;
               job_bytes_in[OFF_RSV_LO]  = cfg.reserved_low;
               job_bytes_in[OFF_RADIUS]  = cfg.broadcast_radius;
               job_bytes_in[OFF_OPTIONS] = cfg.send_options;
               job_bytes_in[OFF_CKSUM]   = CKSUM_BASE - hdr_sum;
               job_err_in   = 1'b0;
               bytes_rem_in = len_sat;
               // an open frame is simply dropped
               if (len_sat == '0) begin
                  job_left_in    = CNT_W'(MAX_RESULTS);
                  job_ck_in      = 1'b1;
                  frame_open_in  = 1'b0;
                  running_sum_in = '0;
               end else begin
                  job_left_in    = CNT_W'(HDR_LEN);
                  job_ck_in      = 1'b0;
                  frame_open_in  = 1'b1;
                  running_sum_in = hdr_sum;
               end
            end
            CMD_DATA: begin
               if (!frame_open_ff) begin
                  job_bytes_in[0] = '0;
                  job_left_in     = CNT_W'(1);
                  job_ck_in       = 1'b0;
                  job_err_in      = 1'b1;
               end else begin
                  job_bytes_in[0] = req_data.payload_byte;
                  job_bytes_in[1] = CKSUM_BASE - data_sum;
                  job_err_in      = 1'b0;
                  bytes_rem_in    = rem_dec;
                  if (rem_dec == '0) begin
                     job_left_in    = CNT_W'(2);
                     job_ck_in      = 1'b1;
                     frame_open_in  = 1'b0;
                     running_sum_in = '0;
                  end else begin
                     job_left_in    = CNT_W'(1);
                     job_ck_in      = 1'b0;
                     running_sum_in = data_sum;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_byte  = job_bytes_ff[0];
         rsp_data_in.frame_end = job_ck_ff && last_byte;
         rsp_data_in.run_end   = last_byte;
         rsp_data_in.error     = job_err_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_left_ff    <= '0;
         running_sum_ff <= '0;
         bytes_rem_ff   <= '0;
         frame_open_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         job_left_ff    <= job_left_in;
         running_sum_ff <= running_sum_in;
         bytes_rem_ff   <= bytes_rem_in;
         frame_open_ff  <= frame_open_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_bytes_ff <= job_bytes_in;
      job_ck_ff    <= job_ck_in;
      job_err_ff   <= job_err_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RTF_ASSERT_IMP(a_left_bound, clock, reset, 1'b1, job_left_ff <= CNT_W'(MAX_RESULTS))
   `RTF_ASSERT_NXT(a_accept_loads, clock, reset, accept, job_left_ff != '0)
   `RTF_ASSERT_IMP(a_open_has_bytes, clock, reset, frame_open_ff, bytes_rem_ff != '0)
   `RTF_ASSERT_IMP(a_error_word, clock, reset, rsp_valid_ff && rsp_data_ff.error,
                   rsp_data_ff.run_end && !rsp_data_ff.frame_end)

endmodule

`default_nettype wire

// ===== hw/rtl/rtf_csr.sv =====
// ----------------------------------------------------------------------------
// Transmit framer register file
// APB-style access to the header configuration bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtf_csr
   import rtf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   byte_type delim_ff,   delim_in;
   byte_type kind_ff,    kind_in;
   byte_type ident_ff,   ident_in;
   byte_type rsv_hi_ff,  rsv_hi_in;
   byte_type rsv_lo_ff,  rsv_lo_in;
   byte_type radius_ff,  radius_in;
   byte_type options_ff, options_in;

   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;
   byte_type             wbyte;
   byte_type             rbyte;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[PADDR_W-1:2];
   assign wbyte   = pwdata[7:0];
   assign pready  = 1'b1;

   always_comb begin
      delim_in   = delim_ff;
      kind_in    = kind_ff;
      ident_in   = ident_ff;
      rsv_hi_in  = rsv_hi_ff;
      rsv_lo_in  = rsv_lo_ff;
      radius_in  = radius_ff;
      options_in = options_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_START_DELIM: delim_in   = wbyte;
            REG_FRAME_KIND:  kind_in    = wbyte;
            REG_FRAME_IDENT: ident_in   = wbyte;
            REG_RSV_HIGH:    rsv_hi_in  = wbyte;
            REG_RSV_LOW:     rsv_lo_in  = wbyte;
            REG_RADIUS:      radius_in  = wbyte;
            REG_OPTIONS:     options_in = wbyte;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_DELIM: rbyte = delim_ff;
         REG_FRAME_KIND:  rbyte = kind_ff;
         REG_FRAME_IDENT: rbyte = ident_ff;
         REG_RSV_HIGH:    rbyte = rsv_hi_ff;
         REG_RSV_LOW:     rbyte = rsv_lo_ff;
         REG_RADIUS:      rbyte = radius_ff;
         REG_OPTIONS:     rbyte = options_ff;
         default:         rbyte = '0;
      endcase
      prdata = {{(PDATA_W-8){1'b0}}, rbyte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff   <= 8'd126;
         kind_ff    <= 8'd16;
         ident_ff   <= 8'd1;
         rsv_hi_ff  <= 8'd255;
         rsv_lo_ff  <= 8'd254;
         radius_ff  <= 8'd0;
         options_ff <= 8'd0;
      end else begin
         delim_ff   <= delim_in;
         kind_ff    <= kind_in;
         ident_ff   <= ident_in;
         rsv_hi_ff  <= rsv_hi_in;
         rsv_lo_ff  <= rsv_lo_in;
         radius_ff  <= radius_in;
         options_ff <= options_in;
      end
   end

   always_comb begin
      cfg.start_delimiter  = delim_ff;
      cfg.frame_kind       = kind_ff;
      cfg.frame_ident      = ident_ff;
      cfg.reserved_high    = rsv_hi_ff;
      cfg.reserved_low     = rsv_lo_ff;
      cfg.broadcast_radius = radius_ff;
      cfg.send_options     = options_ff;
      cfg.cfg_sum          = kind_ff + ident_ff + rsv_hi_ff + rsv_lo_ff
                             + radius_ff + options_ff;
   end

endmodule

`default_nettype wire

// ===== tb/radio_api_transmit_framer_core_tb.sv =====
// ----------------------------------------------------------------------------
// Transmit framer testbench
// Drives start and data words into the framer under random flow control,
// predicts every serialized frame byte, and checks each returned word
// field by field. Header registers are rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_api_transmit_framer_core_tb
   import rtf_pkg::*;
();

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 2 * MAX_RESULTS + 4;
   localparam int NUM_REGS      = 7;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [PADDR_W-1:0]  paddr     = '0;
   logic [PDATA_W-1:0]  pwdata    = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   radio_api_transmit_framer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   req_type           tx_words[$];
   rsp_type           frame_bytes_due[$];
   byte_type          hdr_regs [0:NUM_REGS-1];
   byte_type          run_sum       = '0;
   logic [LEN_W-1:0]  bytes_left    = '0;
   logic              frame_is_open = 1'b0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                err_count     = 0;

   function automatic void owe_byte(byte_type b, logic fend, logic rend, logic err);
      rsp_type r;
      r.out_byte  = b;
      r.frame_end = fend;
      r.run_end   = rend;
      r.error     = err;
      frame_bytes_due.push_back(r);
   endfunction

   // frame bytes caused by one accepted word
   function automatic void serialize_word(req_type w);
      byte_type          hdr [HDR_LEN];
      logic [LEN_W-1:0]  len;
      logic [15:0]       total_len;
      byte_type          sum;
      if (w.command == CMD_START) begin
         len = (w.payload_length > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : w.payload_length;
         total_len = 16'(len) + 16'(LEN_BIAS);
         hdr[OFF_DELIM]   = hdr_regs[REG_START_DELIM];
         hdr[OFF_LEN_HI]  = total_len[15:8];
         hdr[OFF_LEN_LO]  = total_len[7:0];
         hdr[OFF_KIND]    = hdr_regs[REG_FRAME_KIND];
         hdr[OFF_IDENT]   = hdr_regs[REG_FRAME_IDENT];
         for (int i = 0; i < ADDR_BYTES; i++)
            hdr[OFF_ADDR + i] = w.dest_address[8 * (ADDR_BYTES - 1 - i) +: 8];
         hdr[OFF_RSV_HI]  = hdr_regs[REG_RSV_HIGH];
         hdr[OFF_RSV_LO]  = hdr_regs[REG_RSV_LOW];
         hdr[OFF_RADIUS]  = hdr_regs[REG_RADIUS];
         hdr[OFF_OPTIONS] = hdr_regs[REG_OPTIONS];
         sum = '0;
         for (int i = OFF_KIND; i < HDR_LEN; i++)
            sum = sum + hdr[i];
         for (int i = 0; i < HDR_LEN; i++)
            owe_byte(hdr[i], 1'b0, (i == HDR_LEN - 1) && (len != 0), 1'b0);
         if (len == 0) begin
            owe_byte(CKSUM_BASE - sum, 1'b1, 1'b1, 1'b0);
            frame_is_open = 1'b0;
            run_sum       = '0;
         end else begin
            frame_is_open = 1'b1;
            run_sum       = sum;
            bytes_left    = len;
         end
      end else if (!frame_is_open) begin
         owe_byte(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
         run_sum    = run_sum + w.payload_byte;
         bytes_left = bytes_left - 1'b1;
         if (bytes_left == 0) begin
            owe_byte(w.payload_byte, 1'b0, 1'b0, 1'b0);
            owe_byte(CKSUM_BASE - run_sum, 1'b1, 1'b1, 1'b0);
            frame_is_open = 1'b0;
            run_sum       = '0;
         end else begin
            owe_byte(w.payload_byte, 1'b0, 1'b1, 1'b0);
         end
      end
   endfunction

   // unused fields carry random junk so every bit toggles
   function automatic req_type start_word(logic [63:0] addr, logic [LEN_W-1:0] len);
      req_type w;
      w.command        = CMD_START;
      w.dest_address   = addr;
      w.payload_length = len;
      w.payload_byte   = byte_type'($urandom);
      return w;
   endfunction

   function automatic req_type data_word(byte_type b);
      req_type w;
      w.command        = CMD_DATA;
      w.dest_address   = {$urandom, $urandom};
      w.payload_length = LEN_W'($urandom);
      w.payload_byte   = b;
      return w;
   endfunction

   task automatic queue_random_frames(int count);
      int               n;
      int               pick;
      int               ndata;
      logic [LEN_W-1:0] len;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            tx_words.push_back(data_word(byte_type'($urandom)));
            n++;
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5, 6: len = LEN_W'($urandom_range(0, 6));
               7, 8:                len = LEN_W'($urandom_range(7, 40));
               default:             len = LEN_W'($urandom_range(MAX_PAYLOAD, 511));
            endcase
            // broken frames get cut short and abandoned by the next start
            if (len > 40 || pick < 20)
               ndata = $urandom_range(0, 3);
            else
               ndata = len;
            tx_words.push_back(start_word({$urandom, $urandom}, len));
            for (int i = 0; i < ndata; i++)
               tx_words.push_back(data_word(byte_type'($urandom)));
            n += 1 + ndata;
         end
      end
   endtask

   task automatic write_reg(logic [REG_IDX_W-1:0] idx, byte_type val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= PDATA_W'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      hdr_regs[idx] = val;
   endtask

   // fill: 0 all zeros, 1 all ones, else random
   task automatic load_header_regs(int fill);
      byte_type v;
      for (int r = 0; r < NUM_REGS; r++) begin
         v = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : byte_type'($urandom);
         write_reg(REG_IDX_W'(r), v);
      end
   endtask

   // sampled at negedge so all edge updates have settled
   task automatic wait_for_idle();
      do @(negedge clock);
      while (tx_words.size() != 0 || req_valid || frame_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            serialize_word(req_data);
         if (!req_valid || req_ready) begin
            if (tx_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= tx_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               $error("unexpected word: out_byte %0h frame_end %0b run_end %0b error %0b",
                      rsp_data.out_byte, rsp_data.frame_end, rsp_data.run_end,
                      rsp_data.error);
               err_count++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_data.out_byte);
                  err_count++;
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b",
                         want.frame_end, rsp_data.frame_end);
                  err_count++;
               end
               if (rsp_data.run_end !== want.run_end) begin
                  $error("run_end: expected %0b, got %0b", want.run_end, rsp_data.run_end);
                  err_count++;
               end
               if (rsp_data.error !== want.error) begin
                  $error("error: expected %0b, got %0b", want.error, rsp_data.error);
                  err_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (tx_words.size() == 0 && !req_valid && frame_bytes_due.size() == 0))
            quiet = 0;
         else
            quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      hdr_regs[REG_START_DELIM] = 8'd126;
      hdr_regs[REG_FRAME_KIND]  = 8'd16;
      hdr_regs[REG_FRAME_IDENT] = 8'd1;
      hdr_regs[REG_RSV_HIGH]    = 8'd255;
      hdr_regs[REG_RSV_LOW]     = 8'd254;
      hdr_regs[REG_RADIUS]      = 8'd0;
      hdr_regs[REG_OPTIONS]     = 8'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      recv_idle_pct = 61;

      // directed words on the reset header values
      tx_words.push_back(start_word(64'h0, 9'd0));                  // empty frame
      tx_words.push_back(start_word(64'hFFFF_FFFF_FFFF_FFFF, 9'd0));
      tx_words.push_back(data_word(8'h5A));                          // no frame open
      tx_words.push_back(start_word(64'h0123_4567_89AB_CDEF, 9'd1));
      tx_words.push_back(data_word(8'hFF));
      tx_words.push_back(data_word(8'h00));                          // after close
      tx_words.push_back(start_word({$urandom, $urandom}, 9'd2));
      tx_words.push_back(data_word(8'h00));
      tx_words.push_back(data_word(8'hFF));
      tx_words.push_back(start_word({$urandom, $urandom}, 9'd511));  // saturates
      tx_words.push_back(start_word({$urandom, $urandom}, 9'd257));  // abandons open frame
      tx_words.push_back(start_word({$urandom, $urandom}, 9'd256));
      tx_words.push_back(start_word({$urandom, $urandom}, 9'd3));
      tx_words.push_back(data_word(8'h80));
      tx_words.push_back(data_word(8'h7F));
      tx_words.push_back(data_word(8'hA5));
      tx_words.push_back(start_word({$urandom, $urandom}, 9'd5));
      tx_words.push_back(data_word(8'h01));
      tx_words.push_back(data_word(8'hFE));
      tx_words.push_back(start_word({$urandom, $urandom}, 9'd0));  // abandon with empty frame
      wait_for_idle();

      load_header_regs(0);
      queue_random_frames(15);
      wait_for_idle();

      load_header_regs(1);
      queue_random_frames(15);
      wait_for_idle();

      send_idle_pct = 61;
      recv_idle_pct = 17;
      load_header_regs(2);
      queue_random_frames(15);
      wait_for_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_header_regs(2);
      queue_random_frames(15);
      wait_for_idle();

      if (frame_bytes_due.size() != 0) begin
         $error("%0d expected words never arrived", frame_bytes_due.size());
         err_count++;
      end
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
